### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define AST_HOLD(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`else
`define AST_PROP(label, prop, msg)
`define AST_HOLD(label, cond, msg)
`endif
`endif

### hw/rtl/pbpl_pkg.sv
package pbpl_pkg;

   localparam int PAGE_W      = 31;
   localparam int PIN_W       = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [PIN_W-1:0] PIN_MAX = 16'hFFFF;

   localparam logic [2:0] CMD_NEW       = 3'd0;
   localparam logic [2:0] CMD_FETCH     = 3'd1;
   localparam logic [2:0] CMD_UNPIN     = 3'd2;
   localparam logic [2:0] CMD_DELETE    = 3'd3;
   localparam logic [2:0] CMD_FLUSH     = 3'd4;
   localparam logic [2:0] CMD_FLUSH_ALL = 3'd5;

   localparam logic [1:0] DISK_NONE  = 2'd0;
   localparam logic [1:0] DISK_WRITE = 2'd1;
   localparam logic [1:0] DISK_READ  = 2'd2;

   localparam logic REG_INST_COUNT  = 1'b0;
   localparam logic REG_INST_NUMBER = 1'b1;

   typedef struct packed {
      logic [2:0]        command;
      logic [PAGE_W-1:0] page_id;
      logic              dirty_flag;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [3:0]        frame;
      logic [PAGE_W-1:0] page_out;
      logic [1:0]        disk_op;
      logic [PAGE_W-1:0] disk_page;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [PIN_W-1:0]  pins;
   } frame_entry_type;

endpackage

### hw/rtl/page_buffer_pool_lru.sv
// Frame manager of a page buffer pool with LRU replacement. Pulse start with a command
// word while busy is low; the block then emits one or more response words on rsp_data,
// each marked by rsp_valid for exactly one cycle (the receiver cannot stall), and the
// final word carries last and the status. A page lookup walks the frame table memory,
// reading each frame entry and then comparing it, and stops at the first hit; fetch,
// unpin, delete and flush stay busy for the walk. New takes a frame from the free queue,
// else the LRU victim, first writing back a dirty victim, and answers without a frame
// when none is left; a fetch miss does the same after its full walk. Flush-all reads each
// valid frame and emits a write word for it, passing over empty frames. An unknown
// command is answered without raising busy. The next command is taken while busy is low.
// Registers: 0 instance_count, 1 instance_number (loads the next page id).
`include "assert_macros.svh"

module page_buffer_pool_lru #(
   parameter int POOL_FRAMES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pbpl_pkg::req_type req_data,
   output logic              rsp_valid,
   output pbpl_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int FW  = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
   localparam int CW  = $clog2(POOL_FRAMES + 1);
   localparam int RCW = $clog2(pbpl_pkg::MAX_RESULTS);
   localparam logic [FW-1:0]  LAST_FRAME = FW'(POOL_FRAMES - 1);
   localparam logic [CW-1:0]  FULL_CNT   = CW'(POOL_FRAMES);
   localparam logic [RCW-1:0] LAST_SLOT  = RCW'(pbpl_pkg::MAX_RESULTS - 1);

   // sequencer states
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LREAD = 9'b000000010,  // lookup: read frame entry
      ST_LCHK  = 9'b000000100,  // lookup: compare and act
      ST_GRAB  = 9'b000001000,  // take a frame: free queue, else LRU victim
      ST_VRD   = 9'b000010000,  // read dirty victim's page
      ST_VOUT  = 9'b000100000,  // emit victim write-back word
      ST_OCC   = 9'b001000000,  // install page in frame
      ST_FREAD = 9'b010000000,  // flush-all: read next valid frame
      ST_FCHK  = 9'b100000000   // flush-all: emit write word
   } state_type;

   state_type state_ff, state_in;

   // latched command word
   logic [2:0]                  cmd_ff, cmd_in;
   logic [pbpl_pkg::PAGE_W-1:0] page_ff, page_in;
   logic                        dflag_ff, dflag_in;

   logic [FW-1:0]  scan_ff, scan_in;
   logic [FW-1:0]  frame_ff, frame_in;
   logic [RCW-1:0] cnt_ff, cnt_in;

   // per-frame flags in flops; page and pin count live in the table memory
   logic [POOL_FRAMES-1:0] valid_ff, valid_in;
   logic [POOL_FRAMES-1:0] dirty_ff, dirty_in;

   logic [FW-1:0] free_q_ff [POOL_FRAMES];
   logic [FW-1:0] free_q_in [POOL_FRAMES];
   logic [FW-1:0] free_head_ff, free_head_in, free_tail_ff, free_tail_in;
   logic [CW-1:0] free_cnt_ff, free_cnt_in;

   // LRU order: entry 0 is the oldest unpinned frame
   logic [FW-1:0] lru_ff [POOL_FRAMES];
   logic [FW-1:0] lru_in [POOL_FRAMES];
   logic [CW-1:0] lru_cnt_ff, lru_cnt_in;

   logic [pbpl_pkg::PAGE_W-1:0] next_page_ff, next_page_in;
   logic [15:0]                 inst_count_ff, inst_count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   pbpl_pkg::rsp_type rsp_ff, rsp_in;

   // frame table memory
   pbpl_pkg::frame_entry_type table_mem [POOL_FRAMES];
   pbpl_pkg::frame_entry_type rd_data_ff;
   pbpl_pkg::frame_entry_type mem_wd;
   logic [FW-1:0]             mem_wa, rd_addr;
   logic                      mem_we;

   // LRU edit requests from the sequencer
   logic          rm_req, push_req;
   logic [FW-1:0] rm_key, push_key;
   logic          rm_found, push_seen;
   int            rm_pos;

   logic          hit, more, vdirty;
   logic [FW-1:0] vf;

   assign rd_addr = (state_ff == ST_VRD) ? frame_ff : scan_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      page_in       = page_ff;
      dflag_in      = dflag_ff;
      scan_in       = scan_ff;
      frame_in      = frame_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      free_q_in     = free_q_ff;
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      free_cnt_in   = free_cnt_ff;
      lru_in        = lru_ff;
      lru_cnt_in    = lru_cnt_ff;
      next_page_in  = next_page_ff;
      inst_count_in = inst_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      mem_we        = 1'b0;
      mem_wa        = scan_ff;
      mem_wd        = '0;
      rm_req        = 1'b0;
      rm_key        = scan_ff;
      push_req      = 1'b0;
      push_key      = scan_ff;
      vf            = lru_ff[0];
      vdirty        = valid_ff[lru_ff[0]] && dirty_ff[lru_ff[0]];

      hit = valid_ff[scan_ff] && (rd_data_ff.page == page_ff);
      more = 1'b0;
      for (int i = 0; i < POOL_FRAMES; i++) begin
         if (i > int'(scan_ff) && valid_ff[i]) begin
            more = 1'b1;
         end
      end

      if (csr_we) begin
         case (csr_index)
            pbpl_pkg::REG_INST_COUNT:  inst_count_in = csr_wdata;
            pbpl_pkg::REG_INST_NUMBER: next_page_in  = {15'd0, csr_wdata};
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_data.command;
               page_in  = req_data.page_id;
               dflag_in = req_data.dirty_flag;
               scan_in  = '0;
               cnt_in   = '0;
               case (req_data.command)
                  pbpl_pkg::CMD_NEW: state_in = ST_GRAB;
                  pbpl_pkg::CMD_FETCH, pbpl_pkg::CMD_UNPIN,
                  pbpl_pkg::CMD_DELETE, pbpl_pkg::CMD_FLUSH: state_in = ST_LREAD;
                  pbpl_pkg::CMD_FLUSH_ALL: state_in = ST_FREAD;
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                  end
               endcase
            end
         end

         ST_LREAD: state_in = ST_LCHK;

         ST_LCHK: begin
            if (hit) begin
               rsp_valid_in   = 1'b1;
               rsp_in.last    = 1'b1;
               rsp_in.frame   = 4'(scan_ff);
               rsp_in.page_out = page_ff;
               state_in       = ST_IDLE;
               mem_wd.page    = rd_data_ff.page;
               case (cmd_ff)
                  pbpl_pkg::CMD_FETCH: begin
                     if (rd_data_ff.pins != pbpl_pkg::PIN_MAX) begin
                        if (rd_data_ff.pins == '0) begin
                           rm_req = 1'b1;
                        end
                        mem_we      = 1'b1;
                        mem_wd.pins = rd_data_ff.pins + 1'b1;
                        rsp_in.ok   = 1'b1;
                     end
                  end
                  pbpl_pkg::CMD_UNPIN: begin
                     if (rd_data_ff.pins != '0) begin
                        dirty_in[scan_ff] = dirty_ff[scan_ff] | dflag_ff;
                        mem_we      = 1'b1;
                        mem_wd.pins = rd_data_ff.pins - 1'b1;
                        rsp_in.ok   = 1'b1;
                        if (rd_data_ff.pins == pbpl_pkg::PIN_W'(1)) begin
                           push_req = 1'b1;
                           if (dflag_ff) begin
                              rsp_in.disk_op   = pbpl_pkg::DISK_WRITE;
                              rsp_in.disk_page = page_ff;
                           end
                        end
                     end
                  end
                  pbpl_pkg::CMD_DELETE: begin
                     if (rd_data_ff.pins == '0) begin
                        rm_req            = 1'b1;
                        valid_in[scan_ff] = 1'b0;
                        dirty_in[scan_ff] = 1'b0;
                        rsp_in.ok         = 1'b1;
                        if (dirty_ff[scan_ff]) begin
                           rsp_in.disk_op   = pbpl_pkg::DISK_WRITE;
                           rsp_in.disk_page = page_ff;
                        end
                        if (free_cnt_ff < FULL_CNT) begin
                           free_q_in[free_tail_ff] = scan_ff;
                           free_tail_in = (free_tail_ff == LAST_FRAME) ? '0
                                        : free_tail_ff + 1'b1;
                           free_cnt_in  = free_cnt_ff + 1'b1;
                        end
                     end
                  end
                  default: begin  // flush
                     dirty_in[scan_ff] = 1'b0;
                     rsp_in.ok         = 1'b1;
                     rsp_in.disk_op    = pbpl_pkg::DISK_WRITE;
                     rsp_in.disk_page  = page_ff;
                  end
               endcase
            end else if (scan_ff == LAST_FRAME) begin
               if (cmd_ff == pbpl_pkg::CMD_FETCH) begin
                  state_in = ST_GRAB;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.last     = 1'b1;
                  rsp_in.page_out = page_ff;
                  rsp_in.ok       = (cmd_ff == pbpl_pkg::CMD_DELETE);
                  state_in        = ST_IDLE;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_LREAD;
            end
         end

         ST_GRAB: begin
            if (free_cnt_ff != '0) begin
               frame_in     = free_q_ff[free_head_ff];
               free_head_in = (free_head_ff == LAST_FRAME) ? '0 : free_head_ff + 1'b1;
               free_cnt_in  = free_cnt_ff - 1'b1;
               state_in     = ST_OCC;
            end else if (lru_cnt_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rm_req       = 1'b1;
               rm_key       = vf;
               valid_in[vf] = 1'b0;
               dirty_in[vf] = 1'b0;
               frame_in     = vf;
               state_in     = vdirty ? ST_VRD : ST_OCC;
            end
         end

         ST_VRD: state_in = ST_VOUT;

         ST_VOUT: begin
            rsp_valid_in     = 1'b1;
            rsp_in.frame     = 4'(frame_ff);
            rsp_in.page_out  = rd_data_ff.page;
            rsp_in.disk_op   = pbpl_pkg::DISK_WRITE;
            rsp_in.disk_page = rd_data_ff.page;
            state_in         = ST_OCC;
         end

         ST_OCC: begin
            mem_we             = 1'b1;
            mem_wa             = frame_ff;
            mem_wd.pins        = pbpl_pkg::PIN_W'(1);
            valid_in[frame_ff] = 1'b1;
            dirty_in[frame_ff] = 1'b0;
            rsp_valid_in       = 1'b1;
            rsp_in.ok          = 1'b1;
            rsp_in.last        = 1'b1;
            rsp_in.frame       = 4'(frame_ff);
            if (cmd_ff == pbpl_pkg::CMD_NEW) begin
               mem_wd.page    = next_page_ff;
               rsp_in.disk_op = pbpl_pkg::DISK_WRITE;
               next_page_in   = next_page_ff + {15'd0, inst_count_ff};
            end else begin
               mem_wd.page    = page_ff;
               rsp_in.disk_op = pbpl_pkg::DISK_READ;
            end
            rsp_in.page_out  = mem_wd.page;
            rsp_in.disk_page = mem_wd.page;
            state_in         = ST_IDLE;
         end

         ST_FREAD: begin
            if (valid_ff[scan_ff]) begin
               state_in = ST_FCHK;
            end else if (scan_ff == LAST_FRAME) begin
               // no valid frame at all
               rsp_valid_in = 1'b1;
               rsp_in.ok    = 1'b1;
               rsp_in.last  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_FCHK: begin
            dirty_in[scan_ff] = 1'b0;
            rsp_valid_in      = 1'b1;
            rsp_in.frame      = 4'(scan_ff);
            rsp_in.page_out   = rd_data_ff.page;
            rsp_in.disk_op    = pbpl_pkg::DISK_WRITE;
            rsp_in.disk_page  = rd_data_ff.page;
            if (!more || cnt_ff == LAST_SLOT) begin
               rsp_in.ok   = 1'b1;
               rsp_in.last = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               scan_in  = scan_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_FREAD;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // LRU edits: removal closes the gap, push appends if absent
      rm_found = 1'b0;
      rm_pos   = POOL_FRAMES;
      for (int i = 0; i < POOL_FRAMES; i++) begin
         if (!rm_found && i < int'(lru_cnt_ff) && lru_ff[i] == rm_key) begin
            rm_found = 1'b1;
            rm_pos   = i;
         end
      end
      push_seen = 1'b0;
      for (int i = 0; i < POOL_FRAMES; i++) begin
         if (i < int'(lru_cnt_ff) && lru_ff[i] == push_key) begin
            push_seen = 1'b1;
         end
      end
      if (rm_req && rm_found) begin
         for (int j = 0; j < POOL_FRAMES - 1; j++) begin
            if (j >= rm_pos) begin
               lru_in[j] = lru_ff[j+1];
            end
         end
         lru_cnt_in = lru_cnt_ff - 1'b1;
      end
      if (push_req && !push_seen && lru_cnt_ff < FULL_CNT) begin
         lru_in[lru_cnt_ff[FW-1:0]] = push_key;
         lru_cnt_in = lru_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         for (int i = 0; i < POOL_FRAMES; i++) begin
            free_q_ff[i] <= FW'(i);
            lru_ff[i]    <= '0;
         end
         free_head_ff  <= '0;
         free_tail_ff  <= '0;
         free_cnt_ff   <= FULL_CNT;
         lru_cnt_ff    <= '0;
         next_page_ff  <= '0;
         inst_count_ff <= 16'd1;
         rsp_valid_ff  <= 1'b0;
         scan_ff       <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         free_q_ff     <= free_q_in;
         lru_ff        <= lru_in;
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         free_cnt_ff   <= free_cnt_in;
         lru_cnt_ff    <= lru_cnt_in;
         next_page_ff  <= next_page_in;
         inst_count_ff <= inst_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_ff       <= scan_in;
         cnt_ff        <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      page_ff  <= page_in;
      dflag_ff <= dflag_in;
      frame_ff <= frame_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a command ends exactly with its last word
   `AST_PROP(a_end_last, $fell(busy) |-> (rsp_valid && rsp_data.last), "busy fell without last word")
   `AST_HOLD(a_free_cnt, free_cnt_ff <= FULL_CNT, "free queue overfilled")
   `AST_HOLD(a_lru_cnt, lru_cnt_ff <= FULL_CNT, "LRU list overfilled")

endmodule
